// ===== rtl/bitmap_text_rect_generator_macros.svh =====
// Assertion macros shared by the bitmap text rectangle generator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BITMAP_TEXT_RECT_GENERATOR_MACROS_SVH
`define BITMAP_TEXT_RECT_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BTR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("btr assertion failed");
`define BTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btr assertion failed");
`else
`define BTR_ASSERT(label, clk, rst_n, prop)
`define BTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/btr_pkg.sv =====
// Package for the bitmap text rectangle generator: codes, reset values, types.
// No dependencies; imported by every module of the block.
`default_nettype none
package btr_pkg;

	// item kinds
	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_CURSOR = 2'd1;
	localparam logic [1:0] KIND_DRAW   = 2'd2;

	// configuration register indexes (byte address = 4 * index)
	localparam int REG_IDX_W = 3;
	localparam int APB_ADDR_W = 5;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_PIXEL_SCALE  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_DRAW_COLOR   = 3'd4;

	// register reset values
	localparam logic [3:0]  RST_GLYPH_WIDTH  = 4'd3;
	localparam logic [3:0]  RST_GLYPH_HEIGHT = 4'd5;
	localparam logic [4:0]  RST_PIXEL_SCALE  = 5'd4;
	localparam logic [11:0] RST_CANVAS_WIDTH = 12'd640;
	localparam logic [31:0] RST_DRAW_COLOR   = 32'h40FF_FFFF;

	// parameter defaults
	localparam int DEF_GLYPH_SLOTS    = 64;
	localparam int DEF_MAX_GLYPH_BITS = 64;

	localparam int CODE_W = 8;

	typedef struct packed {
		logic [3:0]  glyph_width;
		logic [3:0]  glyph_height;
		logic [4:0]  pixel_scale;
		logic [11:0] canvas_width;
		logic [31:0] draw_color;
	} btr_cfg_t;

	// registered response of the glyph store read port
	typedef struct packed {
		logic              ok;    // a read was issued last cycle
		logic              vld;   // slot holds a loaded glyph
		logic [CODE_W-1:0] code;
	} btr_rd_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/bitmap_text_rect_generator.sv =====
// Top level of the bitmap text rectangle generator.
// Depends on btr_pkg, btr_regs, btr_glyph_store and btr_seq.
//
// Usage:
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. kind selects a glyph slot load, a cursor set or a character draw.
//   Load and cursor items finish at that edge and never raise busy.
//   A draw item raises busy until it is done. The sequencer scans the glyph
//   store one slot per cycle through its registered read port, then walks the
//   matched bitmap one pixel bit per cycle, then steps through ADV1 and ADV2
//   for the cursor advance and line wrap. The walk ends at the top lit pixel
//   bit; when no slot matches, the search goes straight on to the advance.
//   Result channel: one square per strobe cycle, each in the cycle after its
//   pixel is visited, last high on the final square of the character.
//   The receiver cannot stall; every strobed transfer is taken as it comes.
//   Config: APB-style port, register i at byte address 4*i, pready tied high;
//   write only while busy is low.
//   Reset: arst_n clears the registers to defaults, the cursor to (0,0) and
//   all glyph valid flags; glyph memory contents stay undefined until loaded.
`default_nettype none
module bitmap_text_rect_generator
	import btr_pkg::*;
#(
	parameter int GLYPH_SLOTS    = DEF_GLYPH_SLOTS,
	parameter int MAX_GLYPH_BITS = DEF_MAX_GLYPH_BITS
)
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command channel
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            kind,
	input  wire logic [5:0]            slot_index,
	input  wire logic [7:0]            slot_code,
	input  wire logic [63:0]           slot_bitmap,
	input  wire logic signed [12:0]    start_x,
	input  wire logic [11:0]           start_y,
	input  wire logic [7:0]            char_code,
	// result channel
	output logic                       strobe,
	output logic signed [13:0]         rect_x,
	output logic [15:0]                rect_y,
	output logic [4:0]                 rect_side,
	output logic [31:0]                rect_color,
	output logic                       last,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready
);

	localparam int IDX_W  = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;
	localparam int SLOT_CMP_W = 9;   // holds slot_index and slot counts up to 511

	btr_cfg_t            cfg;
	btr_rd_rsp_t         rd_rsp;
	logic [MAX_GLYPH_BITS-1:0] rd_bitmap;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;

	// a load lands in the store on the command transfer itself; slots past
	// the store depth are dropped
	assign wr_en = start && !busy && (kind == KIND_LOAD) &&
		({3'd0, slot_index} < SLOT_CMP_W'(GLYPH_SLOTS));
	assign wr_addr = IDX_W'(slot_index);

	btr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// bits at or beyond MAX_GLYPH_BITS are not stored, so they are never lit
	btr_glyph_store #(
		.GLYPH_SLOTS    (GLYPH_SLOTS),
		.MAX_GLYPH_BITS (MAX_GLYPH_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_code   (slot_code),
		.wr_bitmap (slot_bitmap[MAX_GLYPH_BITS-1:0]),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_rsp    (rd_rsp),
		.rd_bitmap (rd_bitmap)
	);

	btr_seq #(
		.GLYPH_SLOTS    (GLYPH_SLOTS),
		.MAX_GLYPH_BITS (MAX_GLYPH_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.kind       (kind),
		.start_x    (start_x),
		.start_y    (start_y),
		.char_code  (char_code),
		.cfg        (cfg),
		.busy       (busy),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_rsp     (rd_rsp),
		.rd_bitmap  (rd_bitmap),
		.strobe     (strobe),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_side  (rect_side),
		.rect_color (rect_color),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== rtl/btr_regs.sv =====
// Configuration register file behind the APB-style port.
// Depends on btr_pkg.
`default_nettype none
module btr_regs
	import btr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output btr_cfg_t                   cfg
);

	btr_cfg_t cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic wr_en;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.glyph_width  <= RST_GLYPH_WIDTH;
			cfg_q.glyph_height <= RST_GLYPH_HEIGHT;
			cfg_q.pixel_scale  <= RST_PIXEL_SCALE;
			cfg_q.canvas_width <= RST_CANVAS_WIDTH;
			cfg_q.draw_color   <= RST_DRAW_COLOR;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_GLYPH_WIDTH:  cfg_q.glyph_width  <= pwdata[3:0];
				REG_GLYPH_HEIGHT: cfg_q.glyph_height <= pwdata[3:0];
				REG_PIXEL_SCALE:  cfg_q.pixel_scale  <= pwdata[4:0];
				REG_CANVAS_WIDTH: cfg_q.canvas_width <= pwdata[11:0];
				REG_DRAW_COLOR:   cfg_q.draw_color   <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_GLYPH_WIDTH:  prdata = {28'd0, cfg_q.glyph_width};
			REG_GLYPH_HEIGHT: prdata = {28'd0, cfg_q.glyph_height};
			REG_PIXEL_SCALE:  prdata = {27'd0, cfg_q.pixel_scale};
			REG_CANVAS_WIDTH: prdata = {20'd0, cfg_q.canvas_width};
			REG_DRAW_COLOR:   prdata = cfg_q.draw_color;
			default:          prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/btr_glyph_store.sv =====
// Glyph store: one memory of {code, bitmap} entries plus per-slot valid flops.
// Depends on btr_pkg.
`default_nettype none
module btr_glyph_store
	import btr_pkg::*;
#(
	parameter int GLYPH_SLOTS    = DEF_GLYPH_SLOTS,
	parameter int MAX_GLYPH_BITS = DEF_MAX_GLYPH_BITS,
	localparam int IDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1
)
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      wr_en,
	input  wire logic [IDX_W-1:0]          wr_addr,
	input  wire logic [CODE_W-1:0]         wr_code,
	input  wire logic [MAX_GLYPH_BITS-1:0] wr_bitmap,
	input  wire logic                      rd_en,
	input  wire logic [IDX_W-1:0]          rd_addr,
	output btr_rd_rsp_t                    rd_rsp,
	output logic      [MAX_GLYPH_BITS-1:0] rd_bitmap
);

	localparam int ENTRY_W = CODE_W + MAX_GLYPH_BITS;

	logic [ENTRY_W-1:0]     mem [GLYPH_SLOTS];
	logic [ENTRY_W-1:0]     rd_data_q;
	logic [GLYPH_SLOTS-1:0] valid_q;
	logic                   rd_ok_q;
	logic                   rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_code, wr_bitmap};
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rd_ok_q  <= 1'b0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_ok_q <= rd_en;
			if (rd_en) begin
				rd_vld_q <= valid_q[rd_addr];
			end
		end
	end

	assign rd_rsp.ok   = rd_ok_q;
	assign rd_rsp.vld  = rd_vld_q;
	assign rd_rsp.code = rd_data_q[ENTRY_W-1:MAX_GLYPH_BITS];
	assign rd_bitmap   = rd_data_q[MAX_GLYPH_BITS-1:0];

endmodule
`default_nettype wire

// ===== rtl/btr_seq.sv =====
// Sequencer: slot search, per-pixel square emission and cursor advance.
// Depends on btr_pkg and bitmap_text_rect_generator_macros.svh.
`default_nettype none
`include "bitmap_text_rect_generator_macros.svh"
module btr_seq
	import btr_pkg::*;
#(
	parameter int GLYPH_SLOTS    = DEF_GLYPH_SLOTS,
	parameter int MAX_GLYPH_BITS = DEF_MAX_GLYPH_BITS,
	localparam int IDX_W = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1
)
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [1:0]                kind,
	input  wire logic signed [12:0]        start_x,
	input  wire logic [11:0]               start_y,
	input  wire logic [CODE_W-1:0]         char_code,
	input  wire btr_cfg_t                  cfg,
	output logic                           busy,
	output logic                           rd_en,
	output logic      [IDX_W-1:0]          rd_addr,
	input  wire btr_rd_rsp_t               rd_rsp,
	input  wire logic [MAX_GLYPH_BITS-1:0] rd_bitmap,
	output logic                           strobe,
	output logic signed [13:0]             rect_x,
	output logic      [15:0]               rect_y,
	output logic      [4:0]                rect_side,
	output logic      [31:0]               rect_color,
	output logic                           last
);

	localparam int CNT_W = $clog2(GLYPH_SLOTS + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_DRAW   = 3'd2;
	localparam logic [2:0] ST_ADV1   = 3'd3;
	localparam logic [2:0] ST_ADV2   = 3'd4;

	logic [2:0]                state_q;
	logic [CNT_W-1:0]          scan_q;
	logic [CODE_W-1:0]         code_q;
	logic [MAX_GLYPH_BITS-1:0] mask_q;
	logic [3:0]                col_q;
	logic [8:0]                xoff_q;
	logic [8:0]                yoff_q;
	logic [8:0]                cell_q;
	logic [8:0]                row_q;
	logic [13:0]               cx_q;
	logic [15:0]               cy_q;

	logic                      strobe_q;
	logic signed [13:0]        rect_x_q;
	logic [15:0]               rect_y_q;
	logic [4:0]                rect_side_q;
	logic [31:0]               rect_color_q;
	logic                      last_q;

	logic                      accept;
	logic                      hit;
	logic [7:0]                area;
	logic [MAX_GLYPH_BITS-1:0] area_mask;
	logic                      row_end;
	logic signed [14:0]        px;
	logic [16:0]               py;
	logic [9:0]                cell_full;
	logic [9:0]                row_full;
	logic signed [14:0]        nx;
	logic signed [14:0]        nx_far;
	logic [16:0]               ny;

	assign accept  = start && (state_q == ST_IDLE);
	assign busy    = (state_q != ST_IDLE);
	assign rd_en   = (state_q == ST_SEARCH) && (scan_q < CNT_W'(GLYPH_SLOTS));
	assign rd_addr = scan_q[IDX_W-1:0];
	assign hit     = rd_rsp.ok && rd_rsp.vld && (rd_rsp.code == code_q);

	// pixels of the glyph cell, in raster order = bit order
	assign area = {4'd0, cfg.glyph_width} * {4'd0, cfg.glyph_height};
	always_comb begin
		for (int k = 0; k < MAX_GLYPH_BITS; k++) begin
			area_mask[k] = (8'(k) < area);
		end
	end

	assign row_end = (col_q == cfg.glyph_width - 4'd1);
	assign px = $signed({cx_q[13], cx_q}) + $signed({6'd0, xoff_q});
	assign py = {1'b0, cy_q} + {8'd0, yoff_q};

	assign cell_full = {5'd0, {1'b0, cfg.glyph_width} + 5'd1} * {5'd0, cfg.pixel_scale};
	assign row_full  = {5'd0, {1'b0, cfg.glyph_height} + 5'd1} * {5'd0, cfg.pixel_scale};
	assign nx        = $signed({cx_q[13], cx_q}) + $signed({6'd0, cell_q});
	assign nx_far    = nx + $signed({6'd0, cell_q});
	assign ny        = {1'b0, cy_q} + {8'd0, row_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			scan_q   <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (kind)
							KIND_CURSOR: begin
								cx_q <= {start_x[12], start_x};
								cy_q <= {4'd0, start_y};
							end
							KIND_DRAW: begin
								scan_q  <= '0;
								state_q <= ST_SEARCH;
							end
							default: ;
						endcase
					end
				end
				ST_SEARCH: begin
					if (rd_en) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (hit) begin
						state_q <= ST_DRAW;
					end else if (!rd_en && !rd_rsp.ok) begin
						state_q <= ST_ADV1;
					end
				end
				ST_DRAW: begin
					if (mask_q == '0) begin
						state_q <= ST_ADV1;
					end else begin
						strobe_q <= mask_q[0];
					end
				end
				ST_ADV1: begin
					state_q <= ST_ADV2;
				end
				ST_ADV2: begin
					if (nx_far > $signed({3'd0, cfg.canvas_width})) begin
						cx_q <= '0;
						cy_q <= ny[16] ? 16'hFFFF : ny[15:0];
					end else begin
						cx_q <= nx[13:0];
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= char_code;
		end
		if (state_q == ST_SEARCH) begin
			mask_q <= rd_bitmap & area_mask;
			col_q  <= 4'd0;
			xoff_q <= 9'd0;
			yoff_q <= 9'd0;
		end
		if (state_q == ST_DRAW && mask_q != '0) begin
			mask_q <= mask_q >> 1;
			if (row_end) begin
				col_q  <= 4'd0;
				xoff_q <= 9'd0;
				yoff_q <= yoff_q + {4'd0, cfg.pixel_scale};
			end else begin
				col_q  <= col_q + 4'd1;
				xoff_q <= xoff_q + {4'd0, cfg.pixel_scale};
			end
			rect_x_q     <= px[13:0];
			rect_y_q     <= py[16] ? 16'hFFFF : py[15:0];
			rect_side_q  <= cfg.pixel_scale;
			rect_color_q <= cfg.draw_color;
			last_q       <= ((mask_q >> 1) == '0);
		end
		if (state_q == ST_ADV1) begin
			cell_q <= cell_full[8:0];
			row_q  <= row_full[8:0];
		end
	end

	assign strobe     = strobe_q;
	assign rect_x     = rect_x_q;
	assign rect_y     = rect_y_q;
	assign rect_side  = rect_side_q;
	assign rect_color = rect_color_q;
	assign last       = last_q;

	`BTR_ASSERT(a_strobe_busy, clk, arst_n, strobe_q |-> (state_q != ST_IDLE))
	`BTR_ASSERT_NEXT(a_last_ends, clk, arst_n, strobe_q && last_q, !strobe_q)
	`BTR_ASSERT(a_scan_range, clk, arst_n, scan_q <= CNT_W'(GLYPH_SLOTS))
	`BTR_ASSERT(a_draw_width, clk, arst_n, ((state_q == ST_DRAW) && (mask_q != '0)) |-> (col_q < cfg.glyph_width))
	`BTR_ASSERT_NEXT(a_hit_draw, clk, arst_n, (state_q == ST_SEARCH) && hit, state_q == ST_DRAW)

endmodule
`default_nettype wire
